@@ rtl/core/vlad_pkg.sv @@
`timescale 1ns / 1ps
// vlad_pkg: word types, operation and status codes for the value list.
// No dependencies; imported by every file of the block but vlad_ram.
package vlad_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 5;

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_DUMP   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] item;
        logic                     last;
        logic [COUNT_W-1:0]       count;
    } rsp_t;

    typedef struct packed {
        logic load;
        rsp_t word;
    } emit_t;

endpackage

@@ rtl/core/vlad_ram.sv @@
`timescale 1ns / 1ps
// vlad_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module vlad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/vlad_seq.sv @@
`timescale 1ns / 1ps
// vlad_seq: sequencer for append, delete, dump and clear, with the shared
// entry compare and the fill count. Depends on vlad_pkg.
module vlad_seq import vlad_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    input  cmd_t                     cmd,
    output logic                     cmd_stall,
    input  logic                     out_free,
    output emit_t                    emit,
    output logic                     ram_we,
    output logic [$clog2(DEPTH)-1:0] ram_waddr,
    output logic [DATA_W-1:0]        ram_wdata,
    output logic [$clog2(DEPTH)-1:0] ram_raddr,
    input  logic [DATA_W-1:0]        ram_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam logic [FW-1:0] FULL = FW'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DEL  = 4'b0010,
        S_DUMP = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [FW-1:0]     w_reg, w_next;
    status_t           status_reg, status_next;
    logic [DATA_W-1:0] val_reg, val_next;

    logic              keep;
    logic [FW-1:0]     w_inc;
    logic [AW-1:0]     last_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            idx_reg    <= '0;
            w_reg      <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            idx_reg    <= idx_next;
            w_reg      <= w_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    // shared compare: current entry against the delete value
    assign keep     = (ram_rdata != val_reg);
    assign w_inc    = w_reg + FW'(keep);
    assign last_idx = AW'(fill_reg - 1'b1);

    assign cmd_stall = (state_reg != S_IDLE);
    assign ram_raddr = idx_next;

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        w_next      = w_reg;
        status_next = status_reg;
        val_next    = val_reg;
        ram_we      = 1'b0;
        ram_waddr   = AW'(fill_reg);
        ram_wdata   = cmd.value;
        emit        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (func_t'(cmd.func))
                        FUNC_APPEND:
                        begin
                            if (fill_reg == FULL)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                fill_next   = fill_reg + 1'b1;
                                status_next = ST_OK;
                            end
                            state_next = S_RESP;
                        end
                        FUNC_DELETE:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                val_next   = cmd.value;
                                idx_next   = '0;
                                w_next     = '0;
                                state_next = S_DEL;
                            end
                        end
                        FUNC_DUMP:
                        begin
                            if (fill_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                idx_next   = last_idx;
                                state_next = S_DUMP;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            fill_next   = '0;
                            status_next = ST_OK;
                            state_next  = S_RESP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DEL:
            begin
                // survivors copied down; write slot never passes read slot
                if (keep)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(w_reg);
                    ram_wdata = ram_rdata;
                    w_next    = w_inc;
                end
                if (idx_reg == last_idx)
                begin
                    if (w_inc == fill_reg)
                    begin
                        status_next = ST_NOTFOUND;
                    end
                    else
                    begin
                        fill_next   = w_inc;
                        status_next = ST_OK;
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    emit.load        = 1'b1;
                    emit.word.status = ST_OK;
                    emit.word.item   = ram_rdata;
                    emit.word.last   = (idx_reg == '0);
                    emit.word.count  = COUNT_W'(fill_reg);
                    if (idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    emit.load        = 1'b1;
                    emit.word.status = status_reg;
                    emit.word.item   = '0;
                    emit.word.last   = 1'b1;
                    emit.word.count  = COUNT_W'(fill_reg);
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/value_list_append_delete.sv @@
`timescale 1ns / 1ps
// value_list_append_delete: top level of the bounded value list.
// Depends on vlad_pkg, vlad_ram and vlad_seq.
//
// Ordered list of up to DEPTH signed 32-bit values in one RAM, oldest first.
// One command word is taken at a time; cmd_stall is high until its last
// result word has been loaded into the output register. Delete walks the
// list through the single RAM read port and the shared compare, one entry a
// cycle. Dump reads one entry a cycle, newest first, unless rsp_stall holds
// the output register. Reset clears the fill count and control state only;
// no RAM clearing pass.
module value_list_append_delete import vlad_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int AW = $clog2(DEPTH);

    emit_t             emit;
    logic              out_free;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;

    vlad_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    vlad_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_stall (cmd_stall),
        .out_free  (out_free),
        .emit      (emit),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (emit.load)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = emit.word;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/core/vlad_checker.sv @@
`timescale 1ns / 1ps
// vlad_checker: port-level assertions for value_list_append_delete, bound
// to the top level below. Depends on vlad_pkg.
module vlad_checker import vlad_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_stall,
    input cmd_t cmd,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // stalled result word stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result word dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp))
        else $error("result word changed while stalled");

    // one command word at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("command taken while previous one in progress");

    // error results are single words with a zero item
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> rsp.last && (rsp.item == '0))
        else $error("error result not a single zero word");

endmodule

bind value_list_append_delete vlad_checker u_vlad_checker (.*);

@@ verif/value_list_append_delete_tb.sv @@
`timescale 1ns / 1ps
// value_list_append_delete_tb: self-checking bench for the bounded value list.
// Depends on vlad_pkg and value_list_append_delete. A directed table runs first,
// then random words; a queue model of the list scores all but fixed table rows.
module value_list_append_delete_tb;
    import vlad_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int RANDOM_WORDS = 240;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        func_t                    func;
        logic signed [DATA_W-1:0] value;
        logic [7:0]               reps;
        logic                     fixed;
        status_t                  status;
        logic [COUNT_W-1:0]       count;
    } row_t;

    // fixed rows carry their single result word; the rest go to the model
    localparam row_t SCRIPT [0:15] = '{
        '{FUNC_DUMP,   32'sd0,          8'd1,  1'b1, ST_EMPTY,    5'd0},
        '{FUNC_DELETE, 32'sd7,          8'd1,  1'b1, ST_EMPTY,    5'd0},
        '{FUNC_CLEAR,  32'sd0,          8'd1,  1'b1, ST_OK,       5'd0},
        '{FUNC_APPEND, 32'sh80000000,   8'd1,  1'b1, ST_OK,       5'd1},
        '{FUNC_APPEND, 32'sd0,          8'd1,  1'b0, ST_OK,       5'd0},
        '{FUNC_APPEND, 32'sd5,          8'd12, 1'b0, ST_OK,       5'd0},
        '{FUNC_APPEND, 32'sh7fffffff,   8'd1,  1'b0, ST_OK,       5'd0},
        '{FUNC_APPEND, -32'sd1,         8'd1,  1'b1, ST_OK,       5'd16},
        '{FUNC_APPEND, 32'sd42,         8'd1,  1'b1, ST_FULL,     5'd16},
        '{FUNC_DUMP,   32'sd0,          8'd1,  1'b0, ST_OK,       5'd0},
        '{FUNC_DELETE, 32'sd5,          8'd1,  1'b0, ST_OK,       5'd0},
        '{FUNC_DELETE, 32'sd5,          8'd1,  1'b1, ST_NOTFOUND, 5'd4},
        '{FUNC_DELETE, -32'sd1,         8'd1,  1'b0, ST_OK,       5'd0},
        '{FUNC_DELETE, 32'sh80000000,   8'd1,  1'b0, ST_OK,       5'd0},
        '{FUNC_DUMP,   32'sd0,          8'd1,  1'b0, ST_OK,       5'd0},
        '{FUNC_CLEAR,  32'sd0,          8'd1,  1'b1, ST_OK,       5'd0}
    };

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    logic signed [DATA_W-1:0] held[$];
    rsp_t                     pending[$];
    rsp_t                     want;
    int                       errors     = 0;
    int                       cycles     = 0;
    int                       hold_left  = 0;
    bit                       calm       = 1'b0;
    bit                       hold_req   = 1'b0;
    bit                       hold_taken = 1'b0;

    value_list_append_delete #(
        .DEPTH(LIST_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    task automatic queue_word(input status_t st, input logic signed [DATA_W-1:0] item,
                              input logic last, input bit quiet);
        rsp_t w;
        w.status = st;
        w.item   = item;
        w.last   = last;
        w.count  = COUNT_W'(held.size());
        if (!quiet)
            pending.push_back(w);
    endtask

    // list model: updates held and queues the result words of one command
    task automatic list_apply(input cmd_t c, input bit quiet);
        logic signed [DATA_W-1:0] keep[$];
        case (func_t'(c.func))
            FUNC_APPEND:
                if (held.size() >= LIST_DEPTH)
                    queue_word(ST_FULL, '0, 1'b1, quiet);
                else
                begin
                    held.push_back(c.value);
                    queue_word(ST_OK, '0, 1'b1, quiet);
                end
            FUNC_DELETE:
                if (held.size() == 0)
                    queue_word(ST_EMPTY, '0, 1'b1, quiet);
                else
                begin
                    foreach (held[i])
                        if (held[i] !== c.value)
                            keep.push_back(held[i]);
                    if (keep.size() == held.size())
                        queue_word(ST_NOTFOUND, '0, 1'b1, quiet);
                    else
                    begin
                        held = keep;
                        queue_word(ST_OK, '0, 1'b1, quiet);
                    end
                end
            FUNC_DUMP:
                if (held.size() == 0)
                    queue_word(ST_EMPTY, '0, 1'b1, quiet);
                else
                    for (int i = held.size() - 1; i >= 0; i--)
                        queue_word(ST_OK, held[i], i == 0, quiet);
            default:
            begin
                held.delete();
                queue_word(ST_OK, '0, 1'b1, quiet);
            end
        endcase
    endtask

    task automatic send_word(input cmd_t w, input bit fixed, input rsp_t fixed_word);
        while (!calm && $urandom_range(0, 99) < 6)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= w;
        do
            @(posedge clk);
        while (cmd_stall !== 1'b0);
        list_apply(w, fixed);
        if (fixed)
            pending.push_back(fixed_word);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $signed($urandom_range(0, 7)) - 32'sd3;
            1: return $urandom;
            2:
                case ($urandom_range(0, 3))
                    0: return 32'sh80000000;
                    1: return 32'sh7fffffff;
                    2: return -32'sd1;
                    default: return 32'sd0;
                endcase
            default:
                if (held.size() != 0)
                    return held[$urandom_range(0, held.size() - 1)];
                else
                    return $urandom;
        endcase
    endfunction

    // receiver: random stall, plus one long hold so the block backs up
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_taken)
        begin
            rsp_stall  <= 1'b1;
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
        end
        else
            rsp_stall <= !calm && ($urandom_range(0, 99) < 6);
    end

    always @(posedge clk)
    begin
        if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (pending.size() == 0)
                report_mismatch($sformatf("unexpected word status %0d item %0d count %0d",
                                          rsp.status, rsp.item, rsp.count));
            else
            begin
                want = pending.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch($sformatf("status %0d, wanted %0d",
                                              rsp.status, want.status));
                if (rsp.item !== want.item)
                    report_mismatch($sformatf("item %0d, wanted %0d", rsp.item, want.item));
                if (rsp.last !== want.last)
                    report_mismatch($sformatf("last %0b, wanted %0b", rsp.last, want.last));
                if (rsp.count !== want.count)
                    report_mismatch($sformatf("count %0d, wanted %0d",
                                              rsp.count, want.count));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("value_list_append_delete verification failed");
            $finish;
        end
    end

    initial
    begin
        cmd_t w;
        rsp_t fixed_word;
        int   sent;
        int   burst;
        int   roll;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SCRIPT[r])
        begin
            w.func            = SCRIPT[r].func;
            w.value           = SCRIPT[r].value;
            fixed_word.status = SCRIPT[r].status;
            fixed_word.item   = '0;
            fixed_word.last   = 1'b1;
            fixed_word.count  = SCRIPT[r].count;
            repeat (SCRIPT[r].reps)
                send_word(w, SCRIPT[r].fixed, fixed_word);
        end

        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            calm <= (sent >= 100 && sent < 170);
            if (sent >= 40 && !hold_req)
                hold_req <= 1'b1;
            if ($urandom_range(0, 9) == 0)
            begin
                // append run, enough to reach full most times
                burst = $urandom_range(8, 20);
                repeat (burst)
                begin
                    w.func  = FUNC_APPEND;
                    w.value = pick_value();
                    send_word(w, 1'b0, '0);
                    sent++;
                end
            end
            else
            begin
                roll   = $urandom_range(0, 99);
                w.func = (roll < 45) ? FUNC_APPEND :
                         (roll < 73) ? FUNC_DELETE :
                         (roll < 94) ? FUNC_DUMP : FUNC_CLEAR;
                if (w.func == FUNC_DELETE && held.size() != 0 && $urandom_range(0, 3) != 0)
                    w.value = held[$urandom_range(0, held.size() - 1)];
                else
                    w.value = pick_value();
                send_word(w, 1'b0, '0);
                sent++;
            end
        end
        cmd_valid <= 1'b0;

        while (pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("value_list_append_delete verification clean");
        else
            $display("value_list_append_delete verification failed");
        $finish;
    end

endmodule

@@ value_list_append_delete.f @@
rtl/core/vlad_pkg.sv
rtl/core/vlad_ram.sv
rtl/core/vlad_seq.sv
rtl/core/value_list_append_delete.sv
rtl/core/vlad_checker.sv
verif/value_list_append_delete_tb.sv
